@@ rtl/core/hpq_pkg.sv @@
// Shared types and constants for the binary heap priority queue.
// No dependencies; imported by the sequencer and the top level.
package hpq_pkg;

	localparam int HPQ_CAPACITY = 1024;
	localparam int DATA_W       = 32;
	localparam int OCC_W        = 11;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

@@ rtl/core/hpq_mem.sv @@
// Heap storage: simple dual-port RAM, one write and one registered read port.
// Standalone; no package dependency.
module hpq_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH),
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/hpq_ctrl.sv @@
// Insert/remove sequencer: sift-up and sift-down over the heap RAM.
// Depends on hpq_pkg; drives the ports of hpq_mem.
module hpq_ctrl
	import hpq_pkg::*;
#(
	parameter int CAPACITY = HPQ_CAPACITY,
	parameter int AW       = $clog2(CAPACITY),
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     heap_order,
	input  logic                     start,
	input  logic                     command,
	input  logic signed [DATA_W-1:0] data_value,
	output logic                     busy,
	output logic                     done,
	output logic signed [DATA_W-1:0] result_value,
	output logic [1:0]               status,
	output logic [OCC_W-1:0]         occupancy,
	output logic                     mem_we,
	output logic [AW-1:0]            mem_waddr,
	output logic [DATA_W-1:0]        mem_wdata,
	output logic [AW-1:0]            mem_raddr,
	input  logic [DATA_W-1:0]        mem_rdata
);

	localparam int PW = CW + 1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP,
		S_UP_ROOT,
		S_RM_ROOT,
		S_RM_LAST,
		S_DN_CHK,
		S_DN_L,
		S_DN_R,
		S_DN_CMP
	} state_t;

	state_t                     state_q;
	logic [CW-1:0]              count_q;
	logic [AW-1:0]              pos_q;
	logic signed [DATA_W-1:0]   key_q;
	logic signed [DATA_W-1:0]   lv_q;
	logic [AW-1:0]              pick_q;
	logic signed [DATA_W-1:0]   pickv_q;
	logic signed [DATA_W-1:0]   result_q;
	status_t                    status_q;
	logic                       done_q;
	logic [OCC_W-1:0]           occ_q;

	logic signed [DATA_W-1:0]   rd;
	logic [AW-1:0]              parent;
	logic [AW-1:0]              grand;
	logic [AW-1:0]              tail_parent;
	logic [PW-1:0]              left_w;
	logic [PW-1:0]              right_w;
	logic                       up_move;
	logic                       right_wins;
	logic                       dn_move;

	function automatic logic outranks(input logic order, input logic signed [DATA_W-1:0] a,
			input logic signed [DATA_W-1:0] b);
		if (order) begin
			return a < b;
		end
		return a > b;
	endfunction

	assign rd          = $signed(mem_rdata);
	assign parent      = (pos_q - AW'(1)) >> 1;
	assign grand       = (parent - AW'(1)) >> 1;
	assign tail_parent = (count_q[AW-1:0] - AW'(1)) >> 1;
	assign left_w      = PW'({pos_q, 1'b1});
	assign right_w     = left_w + PW'(1);
	assign up_move     = outranks(heap_order, key_q, rd);
	assign right_wins  = outranks(heap_order, rd, lv_q);
	assign dn_move     = outranks(heap_order, pickv_q, key_q);

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = key_q;
		mem_raddr = '0;
		case (state_q)
			S_IDLE: begin
				mem_raddr = (command == CMD_REMOVE) ? '0 : tail_parent;
			end
			S_UP: begin
				mem_we = 1'b1;
				if (up_move) begin
					mem_wdata = rd;
					mem_raddr = grand;
				end
			end
			S_UP_ROOT: begin
				mem_we = 1'b1;
			end
			S_RM_ROOT: begin
				mem_raddr = AW'(count_q - CW'(1));
			end
			S_DN_CHK: begin
				mem_we    = (left_w >= PW'(count_q));
				mem_raddr = left_w[AW-1:0];
			end
			S_DN_L: begin
				mem_raddr = right_w[AW-1:0];
			end
			S_DN_CMP: begin
				mem_we = 1'b1;
				if (dn_move) begin
					mem_wdata = pickv_q;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			done_q   <= 1'b0;
			status_q <= ST_OK;
			occ_q    <= '0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						result_q <= '0;
						if (command == CMD_INSERT) begin
							if (count_q == CW'(CAPACITY)) begin
								done_q   <= 1'b1;
								status_q <= ST_FULL;
								occ_q    <= OCC_W'(count_q);
							end else begin
								key_q   <= data_value;
								pos_q   <= count_q[AW-1:0];
								count_q <= count_q + CW'(1);
								state_q <= (count_q == '0) ? S_UP_ROOT : S_UP;
							end
						end else begin
							if (count_q == '0) begin
								done_q   <= 1'b1;
								status_q <= ST_EMPTY;
								occ_q    <= OCC_W'(count_q);
							end else begin
								state_q <= S_RM_ROOT;
							end
						end
					end
				end
				S_UP: begin
					if (up_move && parent != '0) begin
						pos_q <= parent;
					end else if (up_move) begin
						pos_q   <= parent;
						state_q <= S_UP_ROOT;
					end else begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						occ_q    <= OCC_W'(count_q);
						state_q  <= S_IDLE;
					end
				end
				S_UP_ROOT: begin
					done_q   <= 1'b1;
					status_q <= ST_OK;
					occ_q    <= OCC_W'(count_q);
					state_q  <= S_IDLE;
				end
				S_RM_ROOT: begin
					result_q <= rd;
					count_q  <= count_q - CW'(1);
					state_q  <= S_RM_LAST;
				end
				S_RM_LAST: begin
					key_q <= rd;
					pos_q <= '0;
					if (count_q == '0) begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						occ_q    <= OCC_W'(count_q);
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_DN_CHK;
					end
				end
				S_DN_CHK: begin
					// no left child: key lands here
					if (left_w >= PW'(count_q)) begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						occ_q    <= OCC_W'(count_q);
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_DN_L;
					end
				end
				S_DN_L: begin
					lv_q <= rd;
					if (right_w < PW'(count_q)) begin
						state_q <= S_DN_R;
					end else begin
						pick_q  <= left_w[AW-1:0];
						pickv_q <= rd;
						state_q <= S_DN_CMP;
					end
				end
				S_DN_R: begin
					if (right_wins) begin
						pick_q  <= right_w[AW-1:0];
						pickv_q <= rd;
					end else begin
						pick_q  <= left_w[AW-1:0];
						pickv_q <= lv_q;
					end
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (dn_move) begin
						pos_q   <= pick_q;
						state_q <= S_DN_CHK;
					end else begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						occ_q    <= OCC_W'(count_q);
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign result_value = result_q;
	assign status       = status_q;
	assign occupancy    = occ_q;

endmodule

@@ rtl/core/binary_heap_priority_queue_unit.sv @@
// Top level of the binary heap priority queue: order register, sequencer, heap RAM.
// Depends on hpq_pkg, hpq_mem and hpq_ctrl.
//
// Usage:
//   Command channel: drive command and data_value with start high; the
//   transaction is taken on a rising edge where start is high and busy is low.
//   command 0 inserts data_value, command 1 removes the root.
//   Result channel: done pulses for one cycle with result_value, status and
//   occupancy. The receiver cannot stall; the result must be taken then.
//   Config channel: cfg_data bit 0 picks max-heap (0) or min-heap (1); it is
//   always ready and should only be written while the queue is idle.
// Sequencing:
//   Error results (full insert, empty remove) come in the cycle after start.
//   An insert lifts the value one level per S_UP step until it stops at its place.
//   A remove reads the root, then the last entry, and ends if the queue is now empty;
//   else the moved entry sinks through S_DN_CHK, S_DN_L, S_DN_R (if a right child
//   exists) and S_DN_CMP per level, as the single RAM read port reads both children.
//   A new command may be started in the cycle that done is high.
// Reset: arst_n empties the queue and selects max-heap order; no RAM clearing.
module binary_heap_priority_queue_unit
	import hpq_pkg::*;
#(
	parameter int CAPACITY = HPQ_CAPACITY
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     command,
	input  logic signed [DATA_W-1:0] data_value,
	output logic                     done,
	output logic signed [DATA_W-1:0] result_value,
	output logic [1:0]               status,
	output logic [OCC_W-1:0]         occupancy,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic                     cfg_data
);

	localparam int AW = $clog2(CAPACITY);

	logic              heap_order_q;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_order_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			heap_order_q <= cfg_data;
		end
	end

	hpq_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.heap_order   (heap_order_q),
		.start        (start),
		.command      (command),
		.data_value   (data_value),
		.busy         (busy),
		.done         (done),
		.result_value (result_value),
		.status       (status),
		.occupancy    (occupancy),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	hpq_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW),
		.DW    (DATA_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
